@@ hdl/world_to_screen_projection_assert.svh @@
// Assertion macros shared by the projection block's RTL.
// No dependencies; each use expects signals clk and rst in scope.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define WTSP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define WTSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/wtsp_pkg.sv @@
// Shared types and constants for the world-to-screen projection block.
// No dependencies.
package wtsp_pkg;

  // Item command codes
  localparam logic [1:0] CMD_LOAD_VIEW = 2'd0;
  localparam logic [1:0] CMD_LOAD_PROJ = 2'd1;
  localparam logic [1:0] CMD_POINT     = 2'd2;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int WIN_W = 14;  // viewport size register width
  localparam int QUO_W = 42;  // signed viewport offset from the divider
  localparam int SUM_W = 44;  // offset plus half size before saturation

  localparam logic [WIN_W-1:0] WIDTH_RESET  = 14'd1280;
  localparam logic [WIN_W-1:0] HEIGHT_RESET = 14'd720;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS0,
    S_PASS1,
    S_DIV_START,
    S_DIVIDE,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_LOAD,
    DV_PREP,
    DV_ITER
  } div_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       item_take;  // input transaction this cycle
    logic       mul_issue;  // start one product
    logic       pass;       // 0: times view, 1: times projection
    logic [1:0] row;
    logic [1:0] col;
    logic       div_start;
    logic       out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic w_zero;
    logic div_done;
  } ctrl_status_t;

endpackage

@@ hdl/wtsp_div.sv @@
// Serial scaled divider: |c|*size*2^(FRAC_BITS-1) / |w|, one quotient bit per cycle,
// clamped to 2^40 and signed. Depends on wtsp_pkg and the assertion header.
`include "world_to_screen_projection_assert.svh"
module wtsp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [31:0]                num,
  input  logic [wtsp_pkg::WIN_W-1:0]        size,
  input  logic signed [31:0]                den_in,
  output logic                              done,
  output logic signed [wtsp_pkg::QUO_W-1:0] quotient
);
  import wtsp_pkg::*;

  localparam int NUM_W = 32 + WIN_W;
  localparam int QB    = 42;
  localparam int NW    = NUM_W + FRAC_BITS - 1;
  localparam int CNT_W = $clog2(QB + 1);
  localparam logic [QB-1:0] THR = (QB'(1) << 39) + (QB'(1) << (FRAC_BITS - 1));
  localparam logic [QUO_W-1:0] CLAMP = QUO_W'(1) << 40;

  div_state_t         state;
  logic [31:0]        mag_c;
  logic [31:0]        den;
  logic               neg;
  logic [WIN_W-1:0]   size_r;
  logic [NW-1:0]      numer;
  logic [31:0]        rem;
  logic [QB-1:0]      low;
  logic [QB-1:0]      quo;
  logic               ovf;
  logic [CNT_W-1:0]   cnt;
  logic [32:0]        trial;
  logic               ge;
  logic [QUO_W-1:0]   mag;

  assign trial = {rem, low[QB-1]};
  assign ge    = trial >= {1'b0, den};

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) state <= DV_LOAD;
        end
        DV_LOAD: state <= DV_PREP;
        DV_PREP: begin
          state <= DV_ITER;
          cnt   <= CNT_W'(QB);
        end
        DV_ITER: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= DV_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

  // Operands and restoring long division
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          mag_c  <= num[31] ? (~num + 32'd1) : num;
          den    <= den_in[31] ? (~den_in + 32'd1) : den_in;
          neg    <= num[31] ^ den_in[31];
          size_r <= size;
        end
      end
      DV_LOAD: numer <= {NUM_W'(mag_c * size_r), {(FRAC_BITS - 1){1'b0}}};
      DV_PREP: begin
        rem <= 32'(numer[NW-1:QB]);
        ovf <= 32'(numer[NW-1:QB]) >= den;
        low <= numer[QB-1:0];
        quo <= '0;
      end
      DV_ITER: begin
        rem <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
        low <= low << 1;
        quo <= {quo[QB-2:0], ge};
      end
      default: ;
    endcase
  end

  // Clamp and sign
  assign mag      = (ovf || quo >= THR) ? CLAMP : QUO_W'(quo);
  assign quotient = neg ? $signed(~mag + QUO_W'(1)) : $signed(mag);

  `WTSP_ASSERT_NOW(a_done_after_iter, done, $past(state) == DV_ITER, "done without iteration")
  `WTSP_ASSERT_NEXT(a_start_loads, state == DV_IDLE && start, state == DV_LOAD, "start lost")
  `WTSP_ASSERT_NOW(a_rem_below_den, state == DV_ITER, ovf || rem < den,
    "remainder not below divisor")

endmodule

@@ hdl/wtsp_ctrl.sv @@
// Controller state machine: sequences the 32 multiply-accumulates, the division
// and the output register. Depends on wtsp_pkg and the assertion header.
`include "world_to_screen_projection_assert.svh"
module wtsp_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic [1:0]              command,
  output logic                    item_stall,
  output logic                    result_valid,
  input  logic                    result_stall,
  input  wtsp_pkg::ctrl_status_t  status,
  output wtsp_pkg::ctrl_cmd_t     cmd
);
  import wtsp_pkg::*;

  ctrl_state_t state, state_next;
  logic [4:0]  cnt, cnt_next;
  logic        out_free;

  assign out_free = !result_valid || !result_stall;

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (item_valid && command == CMD_POINT) state_next = S_PASS0;
      end
      S_PASS0, S_PASS1: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd16) begin
          cnt_next   = '0;
          state_next = (state == S_PASS0) ? S_PASS1 : S_DIV_START;
        end
      end
      S_DIV_START: state_next = status.w_zero ? S_FINISH : S_DIVIDE;
      S_DIVIDE: begin
        if (status.div_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_stall    = (state != S_IDLE);
    cmd           = '0;
    cmd.item_take = (state == S_IDLE) && item_valid;
    cmd.mul_issue = (state == S_PASS0 || state == S_PASS1) && !cnt[4];
    cmd.pass      = (state == S_PASS1);
    cmd.row       = cnt[1:0];
    cmd.col       = cnt[3:2];
    cmd.div_start = (state == S_DIV_START) && !status.w_zero;
    cmd.out_load  = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  `WTSP_ASSERT_NOW(a_done_in_divide, status.div_done, state == S_DIVIDE, "stray divider done")
  `WTSP_ASSERT_NEXT(a_load_shows, cmd.out_load, result_valid, "loaded result not shown")
  `WTSP_ASSERT_NOW(a_pass1_after_pass0, state == S_PASS1 && cnt == 5'd0,
    $past(state) == S_PASS0, "projection pass without view pass")

endmodule

@@ hdl/wtsp_datapath.sv @@
// Datapath: matrices, shared multiplier and accumulator, two serial dividers,
// viewport mapping and output register. Depends on wtsp_pkg and wtsp_div.
module wtsp_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wtsp_pkg::ctrl_cmd_t          cmd,
  output wtsp_pkg::ctrl_status_t       status,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [wtsp_pkg::WIN_W-1:0]   cfg_data,
  input  logic [1:0]                   command,
  input  logic [3:0]                   element_index,
  input  logic signed [31:0]           element_value,
  input  logic signed [31:0]           pos_x,
  input  logic signed [31:0]           pos_y,
  input  logic signed [31:0]           pos_z,
  output logic signed [31:0]           screen_x,
  output logic signed [31:0]           screen_y,
  output logic                         w_zero
);
  import wtsp_pkg::*;

  localparam int ACC_W = 66 - FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] A_MAX = ACC_W'(32'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] A_MIN = ACC_W'(32'sh80000000);
  localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(32'sh80000000);

  logic [WIN_W-1:0]   window_width;
  logic [WIN_W-1:0]   window_height;
  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic signed [31:0] pos [3];
  logic signed [31:0] vmid [4];
  logic signed [31:0] clip [4];

  logic signed [31:0] a_op, b_op;
  logic signed [63:0] prod;
  logic               t_valid, t_pass;
  logic [1:0]         t_row, t_col;
  logic signed [ACC_W-1:0] acc, term, sum;
  logic signed [31:0] sum_sat;

  logic               done_x, done_y;
  logic signed [QUO_W-1:0] qx, qy;
  logic signed [SUM_W-1:0] hx, hy, fx, fy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_WIDTH) window_width <= cfg_data;
      if (cfg_index == REG_HEIGHT) window_height <= cfg_data;
    end
  end

  // Matrices, identity after reset, one element per load transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        view_m[i] <= ((i & 3) == (i >> 2)) ? ONE : 32'sd0;
        proj_m[i] <= ((i & 3) == (i >> 2)) ? ONE : 32'sd0;
      end
    end else if (cmd.item_take) begin
      if (command == CMD_LOAD_VIEW) view_m[element_index] <= element_value;
      if (command == CMD_LOAD_PROJ) proj_m[element_index] <= element_value;
    end
  end

  // Point capture
  always_ff @(posedge clk) begin
    if (cmd.item_take && command == CMD_POINT) begin
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
    end
  end

  // Operand select and registered product
  always_comb begin
    if (cmd.pass) a_op = vmid[cmd.row];
    else          a_op = (cmd.row == 2'd3) ? ONE : pos[cmd.row];
    b_op = cmd.pass ? proj_m[{cmd.row, cmd.col}] : view_m[{cmd.row, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (rst) t_valid <= 1'b0;
    else     t_valid <= cmd.mul_issue;
    prod  <= a_op * b_op;
    t_pass <= cmd.pass;
    t_row <= cmd.row;
    t_col <= cmd.col;
  end

  // Accumulate floor-shifted terms, saturate each column
  assign term    = ACC_W'(prod >>> FRAC_BITS);
  assign sum     = ((t_row == 2'd0) ? '0 : acc) + term;
  assign sum_sat = (sum > A_MAX) ? 32'sh7FFFFFFF :
                   (sum < A_MIN) ? 32'sh80000000 : 32'(sum);

  always_ff @(posedge clk) begin
    if (t_valid) begin
      acc <= sum;
      if (t_row == 2'd3) begin
        if (t_pass) clip[t_col] <= sum_sat;
        else        vmid[t_col] <= sum_sat;
      end
    end
  end

  // Perspective divide with viewport scale, x and y in parallel
  wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(clip[0]),
    .size(window_width), .den_in(clip[3]), .done(done_x), .quotient(qx)
  );
  wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(clip[1]),
    .size(window_height), .den_in(clip[3]), .done(done_y), .quotient(qy)
  );

  assign status.w_zero   = (clip[3] == 32'sd0);
  assign status.div_done = done_x & done_y;

  // Viewport offset and saturation
  assign hx = SUM_W'({window_width, {(FRAC_BITS - 1){1'b0}}});
  assign hy = SUM_W'({window_height, {(FRAC_BITS - 1){1'b0}}});
  assign fx = SUM_W'(qx) + hx;
  assign fy = hy - SUM_W'(qy);

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      w_zero <= status.w_zero;
      if (status.w_zero) begin
        screen_x <= clip[0][31] ? 32'sh80000000 : 32'sh7FFFFFFF;
        screen_y <= (clip[1] > 32'sd0) ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        screen_x <= (fx > S_MAX) ? 32'sh7FFFFFFF : (fx < S_MIN) ? 32'sh80000000 : 32'(fx);
        screen_y <= (fy > S_MAX) ? 32'sh7FFFFFFF : (fy < S_MIN) ? 32'sh80000000 : 32'(fy);
      end
    end
  end

endmodule

@@ hdl/world_to_screen_projection.sv @@
// World-to-screen projection top level: controller plus datapath.
// A point is taken while idle; its 32 products run on the one shared multiplier, then
// the bit-serial divide, then the result goes to the output register. The next
// transaction is taken only after that load, which waits while a shown result is stalled.
// A zero w skips the divide. A load transaction leaves the block idle, so another can follow.
// Synchronous reset sets both matrices to identity and the viewport to 1280 by 720.
module world_to_screen_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [wtsp_pkg::WIN_W-1:0]  cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  command,
  input  logic [3:0]                  element_index,
  input  logic signed [31:0]          element_value,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [31:0]          screen_x,
  output logic signed [31:0]          screen_y,
  output logic                        w_zero
);
  import wtsp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  wtsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .item_valid(item_valid), .command(command),
    .item_stall(item_stall), .result_valid(result_valid),
    .result_stall(result_stall), .status(status), .cmd(cmd)
  );

  wtsp_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .command(command), .element_index(element_index), .element_value(element_value),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .screen_x(screen_x), .screen_y(screen_y), .w_zero(w_zero)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for world_to_screen_projection: matrix loads, point
// transactions and viewport settings, each checked against an in-bench predictor.
// Depends on wtsp_pkg and the world_to_screen_projection RTL.
module tb_top;
  import wtsp_pkg::*;

  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 120;
  localparam int ONE_Q = 1 << FRAC;
  localparam logic [1:0] CMD_IGNORED = 2'd3;  // unused command code

  typedef struct {
    logic [1:0]         cmd;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pt_item_t;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               wz;
  } screen_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = REG_WIDTH;
  logic [WIN_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] command = CMD_LOAD_VIEW;
  logic [3:0] element_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic w_zero;

  world_to_screen_projection #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic [WIN_W-1:0]   win_w = WIDTH_RESET;
  logic [WIN_W-1:0]   win_h = HEIGHT_RESET;

  pt_item_t pending_items[$];
  screen_t  expected_screen[$];
  int       errors = 0;
  bit       in_taken = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  pt_item_t drv_item;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Row vector times matrix, floor-shifted products, saturated sums
  function automatic void row_times(input logic signed [31:0] v [4],
                                    input logic signed [31:0] m [16],
                                    output logic signed [31:0] r [4]);
    longint acc;
    for (int j = 0; j < 4; j++) begin
      acc = 0;
      for (int i = 0; i < 4; i++)
        acc += (longint'(v[i]) * longint'(m[i*4+j])) >>> FRAC;
      r[j] = sat32(acc);
    end
  endfunction

  // Truncated c * size * 2^(FRAC-1) / w, clamped near 2^40
  function automatic longint viewport_offset(logic signed [31:0] c, logic [WIN_W-1:0] size,
                                             logic signed [31:0] w);
    bit neg;
    longint unsigned mc, d, n, q0, rem, q;
    neg = (c < 0) != (w < 0);
    mc = (c < 0) ? -longint'(c) : longint'(c);
    d = (w < 0) ? -longint'(w) : longint'(w);
    n = mc * longint'(size);
    q0 = n / d;
    rem = n % d;
    if (q0 > (64'd1 << (40 - FRAC))) q = 64'd1 << 40;
    else q = (q0 << (FRAC - 1)) + ((rem << (FRAC - 1)) / d);
    if (c == 0) return 0;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Apply one accepted transaction; queue the screen point it produces
  function automatic void project_item(pt_item_t it);
    logic signed [31:0] p [4];
    logic signed [31:0] v [4];
    logic signed [31:0] c [4];
    screen_t s;
    case (it.cmd)
      CMD_LOAD_VIEW: view_m[it.idx] = it.val;
      CMD_LOAD_PROJ: proj_m[it.idx] = it.val;
      CMD_POINT: begin
        p[0] = it.x; p[1] = it.y; p[2] = it.z; p[3] = ONE_Q;
        row_times(p, view_m, v);
        row_times(v, proj_m, c);
        if (c[3] == 0) begin
          s.wz = 1'b1;
          s.sx = (c[0] >= 0) ? 32'sh7fffffff : 32'sh80000000;
          s.sy = (c[1] > 0) ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          s.wz = 1'b0;
          s.sx = sat32(viewport_offset(c[0], win_w, c[3]) + (longint'(win_w) << (FRAC - 1)));
          s.sy = sat32((longint'(win_h) << (FRAC - 1)) - viewport_offset(c[1], win_h, c[3]));
        end
        expected_screen.push_back(s);
      end
      default: ;
    endcase
  endfunction

  function automatic int small_val(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] coord_val();
    return ($urandom_range(0, 4) == 0) ? $urandom : small_val(1 << 21);
  endfunction

  task automatic push_item(logic [1:0] cmd, logic [3:0] idx, logic signed [31:0] val,
                           logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    pt_item_t it;
    it = '{cmd, idx, val, x, y, z};
    pending_items.push_back(it);
  endtask

  // Load a whole matrix: near-identity, realistic, or raw random
  task automatic load_matrix(logic [1:0] cmd, int style);
    logic signed [31:0] val;
    for (int i = 0; i < 16; i++) begin
      case (style)
        0: val = (((i & 3) == (i >> 2)) ? ONE_Q : 0) + small_val(1 << 13);
        1: val = small_val(1 << 18);
        default: val = $urandom;
      endcase
      push_item(cmd, i[3:0], val, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic build_random_phase(int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 2) == 0) begin
        load_matrix(CMD_LOAD_VIEW, $urandom_range(0, 4) == 0 ? 2 : $urandom_range(0, 1));
        n += 16;
      end
      if ($urandom_range(0, 2) == 0) begin
        load_matrix(CMD_LOAD_PROJ, $urandom_range(0, 4) == 0 ? 2 : $urandom_range(0, 1));
        n += 16;
      end
      // occasionally flatten the w column to provoke the zero-w path
      if ($urandom_range(0, 5) == 0) begin
        for (int r = 0; r < 4; r++)
          push_item(CMD_LOAD_PROJ, 4'(r * 4 + 3), 0, $urandom, $urandom, $urandom);
        n += 4;
      end
      for (int k = $urandom_range(6, 20); k > 0; k--) begin
        if ($urandom_range(0, 15) == 0)
          push_item(CMD_IGNORED, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        else if ($urandom_range(0, 15) == 0) begin
          push_item(2'($urandom_range(0, 1)), 4'($urandom), $urandom, $urandom, $urandom,
                    $urandom);
          n++;
        end else begin
          push_item(CMD_POINT, 4'($urandom), $urandom, coord_val(), coord_val(), coord_val());
          n++;
        end
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_items.size() != 0 || item_valid || expected_screen.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [WIN_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_WIDTH) win_w = data;
    else win_h = data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus sequencing and final verdict
  initial begin
    logic [WIN_W-1:0] sizes [6][2];
    sizes = '{'{14'd0, 14'd16383}, '{14'd1, 14'd8192}, '{14'd8192, 14'd1},
              '{14'd640, 14'd480}, '{14'd16383, 14'd0}, '{14'd1280, 14'd720}};
    for (int i = 0; i < 16; i++) begin
      view_m[i] = ((i & 3) == (i >> 2)) ? ONE_Q : 0;
      proj_m[i] = view_m[i];
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: origin, field extremes, ignored command, zero w cases
    push_item(CMD_POINT, 4'd0, 0, 0, 0, 0);
    push_item(CMD_POINT, 4'd15, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_item(CMD_POINT, 4'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_item(CMD_POINT, 4'd5, 0, ONE_Q, -ONE_Q, 3 * ONE_Q);
    push_item(CMD_IGNORED, 4'd15, 32'sh7fffffff, -1, -1, -1);
    push_item(CMD_LOAD_VIEW, 4'd12, 32'sh7fffffff, 0, 0, 0);
    push_item(CMD_LOAD_VIEW, 4'd13, 32'sh80000000, 0, 0, 0);
    push_item(CMD_POINT, 4'd0, 0, 1, -1, 0);
    push_item(CMD_LOAD_VIEW, 4'd12, 0, 0, 0, 0);
    push_item(CMD_LOAD_VIEW, 4'd13, 0, 0, 0, 0);
    push_item(CMD_LOAD_PROJ, 4'd15, 0, 0, 0, 0);
    push_item(CMD_POINT, 4'd0, 0, ONE_Q, ONE_Q, 0);
    push_item(CMD_POINT, 4'd0, 0, -ONE_Q, 0, 0);
    push_item(CMD_POINT, 4'd0, 0, 0, -ONE_Q, 0);
    push_item(CMD_LOAD_PROJ, 4'd11, ONE_Q, 0, 0, 0);
    push_item(CMD_LOAD_PROJ, 4'd15, 0, 0, 0, 0);
    push_item(CMD_POINT, 4'd0, 0, 2 * ONE_Q, ONE_Q, ONE_Q / 256);
    push_item(CMD_POINT, 4'd0, 0, 32'sh7fffffff, 32'sh80000000, 1);
    push_item(CMD_LOAD_PROJ, 4'd11, 0, 0, 0, 0);
    push_item(CMD_LOAD_PROJ, 4'd15, ONE_Q, 0, 0, 0);
    push_item(CMD_POINT, 4'd0, 0, -5 * ONE_Q, 7 * ONE_Q, 0);
    wait_quiet();

    // Random phases, each under its own viewport setting
    foreach (sizes[p]) begin
      write_reg(REG_WIDTH, sizes[p][0]);
      write_reg(REG_HEIGHT, sizes[p][1]);
      build_random_phase(120);
      wait_quiet();
    end
    write_reg(REG_WIDTH, WIN_W'($urandom));
    write_reg(REG_HEIGHT, WIN_W'($urandom));
    build_random_phase(20);
    wait_quiet();

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (!rst && (!item_valid || in_taken)) begin
      in_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        command       <= drv_item.cmd;
        element_index <= drv_item.idx;
        element_value <= drv_item.val;
        pos_x         <= drv_item.x;
        pos_y         <= drv_item.y;
        pos_z         <= drv_item.z;
        item_valid    <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern with one long hold-off
  int rx_cycle = 0;
  int hold_left = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle == 3000) hold_left = 2500;
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: check results, predict on input transactions, watchdog
  int idle_cycles = 0;
  screen_t got;
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (cfg_wr_en) idle_cycles = 0;
      if (result_valid && !result_stall) begin
        idle_cycles = 0;
        if (expected_screen.size() == 0) begin
          $error("result transaction with no point outstanding");
          errors++;
        end else begin
          got = expected_screen.pop_front();
          if (screen_x !== got.sx) begin
            $error("screen_x expected %0d got %0d", got.sx, screen_x);
            errors++;
          end
          if (screen_y !== got.sy) begin
            $error("screen_y expected %0d got %0d", got.sy, screen_y);
            errors++;
          end
          if (w_zero !== got.wz) begin
            $error("w_zero expected %0d got %0d", got.wz, w_zero);
            errors++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        idle_cycles = 0;
        in_taken = 1;
        project_item('{command, element_index, element_value, pos_x, pos_y, pos_z});
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/wtsp_pkg.sv
hdl/wtsp_div.sv
hdl/wtsp_ctrl.sv
hdl/wtsp_datapath.sv
hdl/world_to_screen_projection.sv
dv/tb_top.sv
